>>> rtl/csr_diagonal_first_reorder_assert.svh
// Assertion macros shared by the reorder block's modules.
`ifndef CSR_DIAGONAL_FIRST_REORDER_ASSERT_SVH
`define CSR_DIAGONAL_FIRST_REORDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CDFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdfr assertion failed");

// Next-cycle implication, disabled during reset.
`define CDFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdfr assertion failed");

`endif

>>> rtl/cdfr_pkg.sv
// Types and constants for the diagonal-first CSR reorder block.
`default_nettype none
package cdfr_pkg;

  // Rows at or above this index are ignored.
  localparam logic [16:0] ROW_COUNT = 17'd65536;
  // Fill count width, covers row buffers up to 63 entries.
  localparam int FILL_W = 6;

  typedef struct packed {
    logic [15:0] row_index;
    logic [15:0] col_index;
    logic [63:0] entry_value;
    logic        has_entry;
    logic        row_last;
  } item_t;

  typedef struct packed {
    logic [15:0] out_col;
    logic [63:0] out_value;
    logic        inserted;
    logic        overflow;
    logic [31:0] running_end;
    logic        last_of_row;
  } result_t;

  // One buffered off-diagonal entry.
  typedef struct packed {
    logic [15:0] col;
    logic [63:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Finished row handed from the front to the back.
  typedef struct packed {
    logic [15:0]       row;
    logic              diag_seen;
    logic [63:0]       diag_value;
    logic              dropped;
    logic [FILL_W-1:0] fill;
    logic              bank;
  } desc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIAG,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/cdfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cdfr_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/cdfr_front.sv
// Front end: accepts items, classifies diagonal entries, fills the row bank.
`default_nettype none
`include "csr_diagonal_first_reorder_assert.svh"
module cdfr_front #(
  parameter int MAX_ROW_LEN = 32,
  parameter int IDX_W       = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire cdfr_pkg::item_t       item,
  input  wire logic                  row_done,
  output logic                       we,
  output logic [IDX_W:0]             waddr,
  output logic [cdfr_pkg::ENTRY_W-1:0] wdata,
  output logic                       desc_push,
  output cdfr_pkg::desc_t            desc
);
  import cdfr_pkg::*;

  logic [FILL_W-1:0] fill, fill_next;
  logic              diag_seen, diag_seen_next;
  logic [63:0]       diag_value, diag_value_next;
  logic              dropped, dropped_next;
  logic              bank;
  logic [1:0]        rows_out;
  logic              accept, in_range;
  entry_t            wentry;

  // Both banks held by unfinished rows: stall input.
  assign full     = (rows_out == 2'd2);
  assign accept   = push && !full;
  assign in_range = ({1'b0, item.row_index} < ROW_COUNT);

  assign wentry.col   = item.col_index;
  assign wentry.value = item.entry_value;
  assign wdata        = wentry;
  assign waddr        = {bank, fill[IDX_W-1:0]};

  // Classify the item and compute the row state it leaves.
  always_comb begin
    fill_next       = fill;
    diag_seen_next  = diag_seen;
    diag_value_next = diag_value;
    dropped_next    = dropped;
    we              = 1'b0;
    desc_push       = 1'b0;
    if (accept && in_range) begin
      if (item.has_entry) begin
        if ((item.col_index == item.row_index) && !diag_seen) begin
          diag_seen_next  = 1'b1;
          diag_value_next = item.entry_value;
        end else if (fill < FILL_W'(MAX_ROW_LEN)) begin
          we        = 1'b1;
          fill_next = fill + FILL_W'(1);
        end else begin
          dropped_next = 1'b1;
        end
      end
      desc_push = item.row_last;
    end
  end

  assign desc.row        = item.row_index;
  assign desc.diag_seen  = diag_seen_next;
  assign desc.diag_value = diag_value_next;
  assign desc.dropped    = dropped_next;
  assign desc.fill       = fill_next;
  assign desc.bank       = bank;

  // Row state; cleared at each row end.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      diag_seen  <= 1'b0;
      diag_value <= '0;
      dropped    <= 1'b0;
      bank       <= 1'b0;
    end else if (desc_push) begin
      fill       <= '0;
      diag_seen  <= 1'b0;
      diag_value <= '0;
      dropped    <= 1'b0;
      bank       <= ~bank;
    end else begin
      fill       <= fill_next;
      diag_seen  <= diag_seen_next;
      diag_value <= diag_value_next;
      dropped    <= dropped_next;
    end
  end

  // Rows handed over but not yet fully drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_out <= '0;
    end else begin
      rows_out <= rows_out + {1'b0, desc_push} - {1'b0, row_done};
    end
  end

  `CDFR_ASSERT_NOW(a_rows_bounded, clk, rst, 1'b1, rows_out <= 2'd2)
  `CDFR_ASSERT_NOW(a_fill_bounded, clk, rst, 1'b1, fill <= FILL_W'(MAX_ROW_LEN))
  `CDFR_ASSERT_NEXT(a_row_cleared, clk, rst, desc_push, (fill == '0) && !diag_seen && !dropped)

endmodule
`default_nettype wire

>>> rtl/cdfr_queue.sv
// Two-entry row descriptor queue between front and back.
`default_nettype none
module cdfr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cdfr_pkg::desc_t din,
  input  wire logic            pop,
  output logic                 empty,
  output cdfr_pkg::desc_t      dout
);
  import cdfr_pkg::*;

  desc_t      slots [2];
  logic       wp, rp;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign dout  = slots[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> rtl/cdfr_back.sv
// Back end: drains one row, diagonal first, into the result register.
`default_nettype none
`include "csr_diagonal_first_reorder_assert.svh"
module cdfr_back #(
  parameter int IDX_W = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  wire cdfr_pkg::desc_t         q_data,
  output logic                         q_pop,
  output logic                         re,
  output logic [IDX_W:0]               raddr,
  input  wire logic [cdfr_pkg::ENTRY_W-1:0] rdata,
  output logic                         row_done,
  output logic                         empty,
  input  wire logic                    pop,
  output cdfr_pkg::result_t            result
);
  import cdfr_pkg::*;

  back_state_t       state, state_next;
  desc_t             cur;
  logic [FILL_W-1:0] idx, idx_next;
  logic [31:0]       total;
  logic              out_valid;
  logic              slot_free;
  logic              load;
  logic              entry_last;
  result_t           ld;
  entry_t            rd_entry;

  assign rd_entry   = rdata;
  assign slot_free  = !out_valid || pop;
  assign empty      = !out_valid;
  assign raddr      = {cur.bank, idx[IDX_W-1:0]};
  assign entry_last = ((idx + FILL_W'(1)) == cur.fill);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result assembly
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    q_pop          = 1'b0;
    re             = 1'b0;
    load           = 1'b0;
    row_done       = 1'b0;
    ld.out_col     = rd_entry.col;
    ld.out_value   = rd_entry.value;
    ld.inserted    = 1'b0;
    ld.overflow    = cur.dropped;
    ld.running_end = total + 32'd1;
    ld.last_of_row = entry_last;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_DIAG;
        end
      end
      BK_DIAG: begin
        ld.out_col     = cur.row;
        ld.out_value   = cur.diag_seen ? cur.diag_value : 64'd0;
        ld.inserted    = !cur.diag_seen;
        ld.last_of_row = (cur.fill == '0);
        if (slot_free) begin
          load = 1'b1;
          if (cur.fill == '0) begin
            row_done   = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next   = '0;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        re         = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          load     = 1'b1;
          idx_next = idx + FILL_W'(1);
          if (entry_last) begin
            row_done   = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_READ;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Current row and read index
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    idx <= idx_next;
  end

  // Result register and running row-end offset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        total     <= total + 32'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= ld;
    end
  end

  `CDFR_ASSERT_NOW(a_idx_in_row, clk, rst, state == BK_EMIT, idx < cur.fill)
  `CDFR_ASSERT_NEXT(a_diag_kind, clk, rst, load && (state == BK_DIAG), out_valid && (result.inserted != $past(cur.diag_seen)))

endmodule
`default_nettype wire

>>> rtl/csr_diagonal_first_reorder.sv
// After row_last is taken: queue, pop in BK_IDLE, diagonal result load in BK_DIAG.
// Throughput in: 1 item per cycle while one of the two row banks is free.
// Output: per buffered entry, a bank read in BK_READ, then a result load in BK_EMIT
// once the result slot is free; per row also a dispatch, then a diagonal load.
// Reset: synchronous; clears control and counters, bank contents are not cleared.
`default_nettype none
module csr_diagonal_first_reorder #(
  parameter int MAX_ROW_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire cdfr_pkg::item_t     item,
  output logic                     empty,
  input  wire logic                pop,
  output cdfr_pkg::result_t        result
);
  import cdfr_pkg::*;

  localparam int IDX_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int DEPTH = 2 ** (IDX_W + 1);

  logic               we, re;
  logic [IDX_W:0]     waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               desc_push, q_pop, q_empty, row_done;
  desc_t              desc_in, desc_out;

  cdfr_front #(
    .MAX_ROW_LEN(MAX_ROW_LEN),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .row_done (row_done),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .desc_push(desc_push),
    .desc     (desc_in)
  );

  // Two banks of 2**IDX_W entries (at least MAX_ROW_LEN), bank select in the top address bit.
  cdfr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_bank (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  cdfr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (desc_push),
    .din  (desc_in),
    .pop  (q_pop),
    .empty(q_empty),
    .dout (desc_out)
  );

  cdfr_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (desc_out),
    .q_pop   (q_pop),
    .re      (re),
    .raddr   (raddr),
    .rdata   (rdata),
    .row_done(row_done),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

>>> sim/csr_diagonal_first_reorder_tb.sv
// Self-checking testbench for the diagonal-first CSR row reorder block.
`timescale 1ns / 100ps
module csr_diagonal_first_reorder_tb;
  import cdfr_pkg::*;

  localparam int ROW_CAP      = 32;    // row buffer depth of the block
  localparam int STALL_LIMIT  = 5000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 40;    // settle time after the last result
  localparam int DIR_LEN      = 16;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_step_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  // Sideband that travels with the item being offered
  bit      row_typed;
  result_t row_want;

  // Idle percentages and receiver hold-off request
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  // Predictor state
  logic [15:0] pr_col [ROW_CAP];
  logic [63:0] pr_val [ROW_CAP];
  int unsigned pr_fill;
  bit          pr_diag_seen;
  logic [63:0] pr_diag_val;
  bit          pr_dropped;
  logic [31:0] pr_total;

  result_t     pending_entries[$];
  dir_step_t   dir_table [DIR_LEN];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned rows_closed;
  int unsigned results_seen;
  int unsigned overflow_seen;
  int unsigned inserted_seen;
  int unsigned full_stalls;
  int unsigned quiet_cycles;

  csr_diagonal_first_reorder dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue one predicted result and advance the running row end
  function automatic void emit_entry(logic [15:0] c, logic [63:0] v, bit ins, bit last);
    result_t r;
    pr_total      = pr_total + 32'd1;
    r.out_col     = c;
    r.out_value   = v;
    r.inserted    = ins;
    r.overflow    = pr_dropped;
    r.running_end = pr_total;
    r.last_of_row = last;
    pending_entries = {pending_entries, r};
  endfunction

  // Row buffering and diagonal-first emission; row_index is 16 bits so never out of range
  function automatic void reorder_row(item_t it);
    int unsigned k;
    if (it.has_entry) begin
      if (it.col_index == it.row_index && !pr_diag_seen) begin
        pr_diag_seen = 1'b1;
        pr_diag_val  = it.entry_value;
      end else if (pr_fill < ROW_CAP) begin
        pr_col[pr_fill] = it.col_index;
        pr_val[pr_fill] = it.entry_value;
        pr_fill++;
      end else begin
        pr_dropped = 1'b1;
      end
    end
    if (!it.row_last) return;
    rows_closed++;
    emit_entry(it.row_index, pr_diag_seen ? pr_diag_val : 64'd0, !pr_diag_seen, pr_fill == 0);
    for (k = 0; k < pr_fill; k++)
      emit_entry(pr_col[k], pr_val[k], 1'b0, k + 1 == pr_fill);
    pr_fill      = 0;
    pr_diag_seen = 1'b0;
    pr_diag_val  = 64'd0;
    pr_dropped   = 1'b0;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Scoreboard: results are checked before this edge's input is predicted
  always @(posedge clk) begin : scoreboard_b
    result_t want_r;
    if (!rst) begin
      if (pop && !empty) begin
        results_seen++;
        if (result.overflow) overflow_seen++;
        if (result.inserted) inserted_seen++;
        if (pending_entries.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected transaction, expected none, actual %h", $time, result);
        end else begin
          want_r = pending_entries.pop_front();
          check_field("out_col",     64'(want_r.out_col),     64'(result.out_col));
          check_field("out_value",   want_r.out_value,        result.out_value);
          check_field("inserted",    64'(want_r.inserted),    64'(result.inserted));
          check_field("overflow",    64'(want_r.overflow),    64'(result.overflow));
          check_field("running_end", 64'(want_r.running_end), 64'(result.running_end));
          check_field("last_of_row", 64'(want_r.last_of_row), 64'(result.last_of_row));
        end
      end
      if (push && full) full_stalls++;
      if (push && !full) begin
        reorder_row(item);
        // Hand-written expectation replaces the predicted single result
        if (row_typed) pending_entries[pending_entries.size() - 1] = row_want;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random pop, with a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item at the falling edge and wait for its transaction
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    item      <= it;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic item_t make_item(logic [15:0] r, logic [15:0] c, logic [63:0] v,
                                      bit has, bit last);
    item_t it;
    it.row_index   = r;
    it.col_index   = c;
    it.entry_value = v;
    it.has_entry   = has;
    it.row_last    = last;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One random row: mostly short, some past the buffer, some empty, with noise
  task automatic send_random_row();
    result_t     none;
    logic [15:0] r;
    logic [15:0] c;
    int          len;
    int          diag_pos;
    int          diag2_pos;
    int          kind;
    bit          marker_end;
    item_t       it;
    none = '0;
    r    = 16'($urandom);
    kind = $urandom_range(99);
    if (kind < 8)       len = $urandom_range(38, 33);
    else if (kind < 16) len = 0;
    else                len = $urandom_range(6, 1);
    diag_pos   = (len > 0 && $urandom_range(99) < 60) ? $urandom_range(len - 1) : -1;
    diag2_pos  = (len > 1 && $urandom_range(99) < 10) ? $urandom_range(len - 1) : -1;
    marker_end = (len == 0) || ($urandom_range(99) < 10);
    for (int i = 0; i < len; i++) begin
      // Marker without row end: ignored by the block
      if ($urandom_range(99) < 4)
        send_item(make_item(16'($urandom), 16'($urandom), rand64(), 1'b0, 1'b0), 1'b0, none);
      c  = (i == diag_pos || i == diag2_pos) ? r : 16'($urandom);
      it = make_item(r, c, rand64(), 1'b1, !marker_end && i == len - 1);
      // Broken row: stray row number on a few items
      if ($urandom_range(99) < 3) it.row_index = 16'($urandom);
      send_item(it, 1'b0, none);
      items_sent++;
    end
    if (marker_end) begin
      send_item(make_item(r, 16'($urandom), rand64(), 1'b0, 1'b1), 1'b0, none);
      items_sent++;
    end
  endtask

  // Stop offering and let every predicted result come out
  task automatic drain();
    push <= 1'b0;
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, int unsigned upto,
                           bit with_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (with_hold) begin
      @(posedge clk);
      hold_req = 1'b1;
      @(negedge clk);
    end
    while (items_sent < upto) send_random_row();
    drain();
  endtask

  // Directed rows; hand-written expectations only where they are obvious
  task automatic load_dir_table();
    result_t none;
    none = '0;
    // Empty-row marker right after reset
    dir_table[0]  = '{make_item(16'h0000, 16'h1234, 64'h0, 1'b0, 1'b1), 1'b1,
                      '{16'h0000, 64'h0, 1'b1, 1'b0, 32'd1, 1'b1}};
    // Diagonal-only row at the top corner, all-ones value
    dir_table[1]  = '{make_item(16'hFFFF, 16'hFFFF, '1, 1'b1, 1'b1), 1'b1,
                      '{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd2, 1'b1}};
    dir_table[2]  = '{make_item(16'hFFFF, 16'h0000, 64'h0, 1'b0, 1'b1), 1'b1,
                      '{16'hFFFF, 64'h0, 1'b1, 1'b0, 32'd3, 1'b1}};
    // Row 5: ignored marker, off-diagonal, diagonal, repeated diagonal, closer
    dir_table[3]  = '{make_item(16'd5, 16'd5, 64'h1, 1'b0, 1'b0), 1'b0, none};
    dir_table[4]  = '{make_item(16'd5, 16'd7, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0), 1'b0, none};
    dir_table[5]  = '{make_item(16'd5, 16'd5, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0), 1'b0, none};
    dir_table[6]  = '{make_item(16'd5, 16'd5, 64'h5555_5555_5555_5555, 1'b1, 1'b0), 1'b0, none};
    dir_table[7]  = '{make_item(16'd5, 16'd0, 64'h0, 1'b1, 1'b1), 1'b0, none};
    // Row 9: no diagonal, zero inserted ahead of the entries
    dir_table[8]  = '{make_item(16'd9, 16'd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0), 1'b0, none};
    dir_table[9]  = '{make_item(16'd9, 16'hFFFF, 64'h8000_0000_0000_0000, 1'b1, 1'b1), 1'b0, none};
    // Row 0: diagonal after an entry, row closed by a marker
    dir_table[10] = '{make_item(16'd0, 16'hFFFF, 64'h0, 1'b1, 1'b0), 1'b0, none};
    dir_table[11] = '{make_item(16'd0, 16'd0, '1, 1'b1, 1'b0), 1'b0, none};
    dir_table[12] = '{make_item(16'd0, 16'd0, 64'h1, 1'b0, 1'b1), 1'b0, none};
    // Diagonal with zero value is not an inserted one
    dir_table[13] = '{make_item(16'd3, 16'd3, 64'h0, 1'b1, 1'b1), 1'b1,
                      '{16'd3, 64'h0, 1'b0, 1'b0, 32'd13, 1'b1}};
    dir_table[14] = '{make_item(16'h7FFF, 16'h8000, 64'h1, 1'b1, 1'b1), 1'b0, none};
    dir_table[15] = '{make_item(16'h8000, 16'h8000, 64'h8000_0000_0000_0000, 1'b1, 1'b1),
                      1'b0, none};
  endtask

  // Main sequence
  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    item          = '0;
    row_typed     = 1'b0;
    row_want      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pr_fill       = 0;
    pr_diag_seen  = 1'b0;
    pr_diag_val   = 64'd0;
    pr_dropped    = 1'b0;
    pr_total      = 32'd0;
    mismatches    = 0;
    items_sent    = 0;
    rows_closed   = 0;
    results_seen  = 0;
    overflow_seen = 0;
    inserted_seen = 0;
    full_stalls   = 0;
    quiet_cycles  = 0;
    load_dir_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows, receiver idling now and then
    recv_idle_pct = 30;
    for (int i = 0; i < DIR_LEN; i++) begin
      send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].want);
      if (dir_table[i].it.has_entry || dir_table[i].it.row_last) items_sent++;
    end
    drain();

    // Random rows in three idling regimes; the last one opens with a long hold-off
    run_phase(6, 55, 170, 1'b0);
    run_phase(55, 6, 310, 1'b0);
    run_phase(0, 0, 450, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d items in %0d rows, %0d results checked", items_sent, rows_closed,
             results_seen);
    $display("Inserted diagonals %0d, overflow results %0d, input stall cycles %0d",
             inserted_seen, overflow_seen, full_stalls);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/cdfr_pkg.sv
rtl/cdfr_ram.sv
rtl/cdfr_front.sv
rtl/cdfr_queue.sv
rtl/cdfr_back.sv
rtl/csr_diagonal_first_reorder.sv
sim/csr_diagonal_first_reorder_tb.sv
